@@ design/range_allocator_free_list_macros.svh @@
// Assertion macros for the range allocator.
// No dependencies; the top level includes it to check its own logic.
`ifndef RANGE_ALLOCATOR_FREE_LIST_MACROS_SVH
`define RANGE_ALLOCATOR_FREE_LIST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RAL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("range allocator check failed");
`define RAL_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`else
`define RAL_ASSERT(lbl, prop)
`define RAL_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

@@ design/ral_pkg.sv @@
// Shared types and codes of the range allocator.
// No dependencies; used by the cells, the chain and the top level.
`default_nettype none
package ral_pkg;
    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } t_range;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT,
        OP_WRITE,
        OP_INS,
        OP_REM
    } t_chain_op;

    typedef struct packed {
        t_chain_op op;
        t_range    entry;
    } t_chain_ctl;

    localparam logic [2:0] K_INIT = 3'd0;
    localparam logic [2:0] K_LOW  = 3'd1;
    localparam logic [2:0] K_HIGH = 3'd2;
    localparam logic [2:0] K_AT   = 3'd3;
    localparam logic [2:0] K_FREE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic REG_PARTITION_BASE = 1'b0;
    localparam logic REG_PARTITION_SIZE = 1'b1;

    localparam logic [4:0]  MIN_ALIGN_LOG2 = 5'd8;
    localparam logic [31:0] FIXED_MASK     = 32'h0000_00FF;
endpackage
`default_nettype wire

@@ design/ral_cell.sv @@
// One table cell: holds one entry and takes a neighbor's entry on shift operations.
// Depends on ral_pkg.
`default_nettype none
module ral_cell
    import ral_pkg::*;
#(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  wire logic    i_clk,
    input  wire t_chain_ctl i_ctl,
    input  wire logic [IW-1:0] i_pos,
    input  wire t_range i_prev,
    input  wire t_range i_next,
    output t_range      o_entry
);
    localparam logic [IW-1:0] MY = IW'(IDX);

    t_range r_entry;
    t_range n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_ROT: n_entry = i_next;
            OP_WRITE: begin
                if (MY == i_pos) n_entry = i_ctl.entry;
            end
            OP_INS: begin
                if (MY > i_pos) n_entry = i_prev;
                else if (MY == i_pos) n_entry = i_ctl.entry;
            end
            OP_REM: begin
                if (MY >= i_pos) n_entry = i_next;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

@@ design/ral_chain.sv @@
// A ring of table cells; rotation walks every entry past the head cell.
// Depends on ral_pkg and ral_cell.
`default_nettype none
module ral_chain
    import ral_pkg::*;
#(
    parameter int DEPTH = 32,
    localparam int IW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire t_chain_ctl    i_ctl,
    input  wire logic [IW-1:0] i_pos,
    output t_range             o_head
);
    t_range w_entry [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_range w_prev;
        t_range w_next;
        if (k == 0) begin : g_first
            assign w_prev = i_ctl.entry;
        end else begin : g_mid
            assign w_prev = w_entry[k-1];
        end
        assign w_next = w_entry[(k + 1) % DEPTH];
        ral_cell #(.IW(IW), .IDX(k)) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_pos  (i_pos),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_entry(w_entry[k])
        );
    end

    assign o_head = w_entry[0];
endmodule
`default_nettype wire

@@ design/range_allocator_free_list.sv @@
// Range allocator: first fit (low), highest fit (high) or fixed address, with coalescing;
// one word in flight at a time. A word passes a check step, a full rotation of the used
// ring (free only), a full rotation of the free ring, one or two edit steps and a done
// step; init and early rejects go from check to done, an unknown free from the used scan.
// A new word is taken in the idle state after the result leaves, after any output stall.
// Synchronous active-low reset empties both tables and clears the free total at once.
`default_nettype none
`include "range_allocator_free_list_macros.svh"
module range_allocator_free_list
    import ral_pkg::*;
#(
    parameter int FREE_RANGES = 32,
    parameter int USED_BLOCKS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_request_size,
    input  wire logic [4:0]  i_alignment_log2,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [31:0]      o_block_address,
    output logic [31:0]      o_block_size,
    output logic [31:0]      o_free_bytes,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int FW = $clog2(FREE_RANGES);
    localparam int FC = $clog2(FREE_RANGES + 1);
    localparam int UW = $clog2(USED_BLOCKS);
    localparam int UC = $clog2(USED_BLOCKS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SCAN_U, S_SCAN_F, S_EDIT1, S_EDIT2, S_DONE
    } t_state;

    t_state r_state;
    logic [31:0] r_base, r_psize;
    logic [2:0]  r_kind;
    logic [31:0] r_addr, r_req;
    logic [4:0]  r_lg;
    logic [31:0] r_mask;
    logic [32:0] r_s;
    logic [FC-1:0] r_fcnt;
    logic [UC-1:0] r_ucnt;
    logic [31:0] r_ftot;
    logic [FW-1:0] r_cf, r_fi;
    logic [UW-1:0] r_cu, r_u;
    logic        r_found, r_gotnext;
    logic [31:0] r_a, r_el, r_eh, r_nl, r_nh, r_len;
    logic [FC-1:0] r_p;
    t_range      r_last;
    logic [32:0] r_end;
    logic [2:0]  r_st;
    logic [31:0] r_ra, r_rs;
    logic        r_out_valid;
    logic [2:0]  r_o_status;
    logic [31:0] r_o_addr, r_o_size, r_o_free;

    t_chain_ctl    f_ctl, u_ctl;
    logic [FW-1:0] f_pos;
    logic [UW-1:0] u_pos;
    t_range        fe, ue;

    ral_chain #(.DEPTH(FREE_RANGES)) u_free (
        .i_clk(i_clk), .i_ctl(f_ctl), .i_pos(f_pos), .o_head(fe)
    );
    ral_chain #(.DEPTH(USED_BLOCKS)) u_used (
        .i_clk(i_clk), .i_ctl(u_ctl), .i_pos(u_pos), .o_head(ue)
    );

    // Request sizing.
    logic [4:0]  lg_eff;
    logic [31:0] mask_c;
    logic [32:0] s_c;
    logic [31:0] room, sz;
    assign lg_eff = (r_lg < MIN_ALIGN_LOG2) ? MIN_ALIGN_LOG2 : r_lg;
    assign mask_c = (r_kind == K_AT) ? FIXED_MASK : ((32'd1 << lg_eff) - 32'd1);
    assign s_c    = ({1'b0, r_req} + {1'b0, mask_c}) & ~{1'b0, mask_c};
    assign room   = 32'hFFFF_FFFF - r_base;
    assign sz     = (r_psize < room) ? r_psize : room;

    // Per-entry tests on the head of the free ring.
    logic        fv, fit_lo, fit_hi, fit_at, below;
    logic [32:0] a_lo;
    logic [31:0] top, a_hi;
    assign fv     = FC'(r_cf) < r_fcnt;
    assign a_lo   = ({1'b0, fe.lo} + {1'b0, r_mask}) & ~{1'b0, r_mask};
    assign fit_lo = (a_lo < {1'b0, fe.hi}) &&
                    (({1'b0, a_lo} + {1'b0, r_s}) <= {2'b0, fe.hi});
    assign top    = fe.hi & ~r_mask;
    assign fit_hi = (top > fe.lo) && (({1'b0, top} - {1'b0, fe.lo}) >= r_s);
    assign a_hi   = top - r_s[31:0];
    assign fit_at = (fe.lo <= r_addr) &&
                    (({1'b0, r_addr} + r_s) <= {1'b0, fe.hi});
    assign below  = {1'b0, fe.lo} < r_end;

    logic uv, umatch, ulast;
    assign uv     = UC'(r_cu) < r_ucnt;
    assign umatch = uv && (ue.lo == r_addr);
    assign ulast  = uv && ((UC'(r_cu) + UC'(1)) == r_ucnt);

    // Edit decisions.
    logic        is_free, left, right, ffull, prev_t, next_t, need_new, two_step;
    logic [33:0] aend;
    logic [FC-1:0] p_m1;
    assign is_free  = (r_kind == K_FREE);
    assign aend     = {2'b0, r_a} + {1'b0, r_s};
    assign left     = r_a > r_el;
    assign right    = aend < {2'b0, r_eh};
    assign ffull    = (r_fcnt == FC'(FREE_RANGES));
    assign prev_t   = (r_p != '0) && (r_eh == r_a);
    assign next_t   = r_gotnext && ({1'b0, r_nl} == r_end);
    assign need_new = is_free ? (!prev_t && !next_t) : (left && right);
    assign two_step = is_free ? (prev_t && next_t) : (r_found && left && right && !ffull);
    assign p_m1     = r_p - FC'(1);

    always_comb begin
        f_ctl = '{op: OP_HOLD, entry: '0};
        u_ctl = '{op: OP_HOLD, entry: '0};
        f_pos = '0;
        u_pos = '0;
        case (r_state)
            S_CHECK: begin
                if (r_kind == K_INIT) begin
                    f_ctl = '{op: OP_WRITE, entry: '{lo: r_base, hi: r_base + sz}};
                end
            end
            S_SCAN_F: f_ctl.op = OP_ROT;
            S_SCAN_U: u_ctl.op = OP_ROT;
            S_EDIT1: begin
                if (!is_free && r_found && !(need_new && ffull)) begin
                    u_ctl = '{op: OP_WRITE, entry: '{lo: r_a, hi: r_s[31:0]}};
                    u_pos = r_ucnt[UW-1:0];
                    f_pos = r_fi;
                    if (left) begin
                        f_ctl = '{op: OP_WRITE, entry: '{lo: r_el, hi: r_a}};
                    end else if (right) begin
                        f_ctl = '{op: OP_WRITE, entry: '{lo: aend[31:0], hi: r_eh}};
                    end else begin
                        f_ctl.op = OP_REM;
                    end
                end else if (is_free && !(need_new && ffull)) begin
                    u_ctl = '{op: OP_WRITE, entry: r_last};
                    u_pos = r_u;
                    if (prev_t && next_t) begin
                        f_ctl = '{op: OP_WRITE, entry: '{lo: r_el, hi: r_nh}};
                        f_pos = p_m1[FW-1:0];
                    end else if (prev_t) begin
                        f_ctl = '{op: OP_WRITE, entry: '{lo: r_el, hi: r_end[31:0]}};
                        f_pos = p_m1[FW-1:0];
                    end else if (next_t) begin
                        f_ctl = '{op: OP_WRITE, entry: '{lo: r_a, hi: r_nh}};
                        f_pos = r_p[FW-1:0];
                    end else begin
                        f_ctl = '{op: OP_INS, entry: '{lo: r_a, hi: r_end[31:0]}};
                        f_pos = r_p[FW-1:0];
                    end
                end
            end
            S_EDIT2: begin
                if (is_free) begin
                    f_ctl.op = OP_REM;
                    f_pos = r_p[FW-1:0];
                end else begin
                    f_ctl = '{op: OP_INS, entry: '{lo: aend[31:0], hi: r_eh}};
                    f_pos = r_fi + FW'(1);
                end
            end
            default: f_ctl.op = OP_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_psize     <= '0;
            r_fcnt      <= '0;
            r_ucnt      <= '0;
            r_ftot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_PARTITION_SIZE) r_psize <= i_cfg_data;
                else r_base <= i_cfg_data;
            end
            if (r_out_valid && !i_stall && r_state != S_DONE) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_addr  <= (i_kind == K_AT) ? (i_address & ~FIXED_MASK) : i_address;
                        r_req   <= i_request_size;
                        r_lg    <= i_alignment_log2;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_mask    <= mask_c;
                    r_s       <= s_c;
                    r_found   <= 1'b0;
                    r_gotnext <= 1'b0;
                    r_p       <= '0;
                    r_cf      <= '0;
                    r_cu      <= '0;
                    r_ra      <= (r_kind == K_INIT) ? r_base : '0;
                    r_rs      <= (r_kind == K_INIT) ? sz : '0;
                    case (r_kind)
                        K_INIT: begin
                            r_ucnt  <= '0;
                            r_fcnt  <= (sz != '0) ? FC'(1) : '0;
                            r_ftot  <= sz;
                            r_st    <= ST_OK;
                            r_state <= S_DONE;
                        end
                        K_LOW, K_HIGH, K_AT: begin
                            if (r_req == '0) begin
                                r_st    <= ST_ZERO;
                                r_state <= S_DONE;
                            end else if (s_c > {1'b0, r_ftot}) begin
                                r_st    <= ST_NOFIT;
                                r_state <= S_DONE;
                            end else if (r_ucnt == UC'(USED_BLOCKS)) begin
                                r_st    <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SCAN_F;
                            end
                        end
                        K_FREE: r_state <= S_SCAN_U;
                        default: begin
                            r_st    <= ST_NOFIT;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SCAN_U: begin
                    r_cu <= r_cu + UW'(1);
                    if (umatch && !r_found) begin
                        r_found <= 1'b1;
                        r_u     <= r_cu;
                        r_len   <= ue.hi;
                    end
                    if (ulast) r_last <= ue;
                    if (r_cu == UW'(USED_BLOCKS - 1)) begin
                        r_a   <= r_addr;
                        r_end <= {1'b0, r_addr} +
                                 {1'b0, (r_found ? r_len : ue.hi)};
                        if (!r_found && !umatch) begin
                            r_st    <= ST_NOTFOUND;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN_F;
                        end
                    end
                end
                S_SCAN_F: begin
                    r_cf <= r_cf + FW'(1);
                    if (fv) begin
                        case (r_kind)
                            K_LOW, K_AT: begin
                                if (!r_found && (r_kind == K_LOW ? fit_lo : fit_at)) begin
                                    r_found <= 1'b1;
                                    r_fi    <= r_cf;
                                    r_a     <= (r_kind == K_LOW) ? a_lo[31:0] : r_addr;
                                    r_el    <= fe.lo;
                                    r_eh    <= fe.hi;
                                end
                            end
                            K_HIGH: begin
                                // The highest fitting range wins.
                                if (fit_hi) begin
                                    r_found <= 1'b1;
                                    r_fi    <= r_cf;
                                    r_a     <= a_hi;
                                    r_el    <= fe.lo;
                                    r_eh    <= fe.hi;
                                end
                            end
                            default: begin
                                if (below) begin
                                    r_p  <= FC'(r_cf) + FC'(1);
                                    r_el <= fe.lo;
                                    r_eh <= fe.hi;
                                end else if (!r_gotnext) begin
                                    r_gotnext <= 1'b1;
                                    r_nl      <= fe.lo;
                                    r_nh      <= fe.hi;
                                end
                            end
                        endcase
                    end
                    if (r_cf == FW'(FREE_RANGES - 1)) r_state <= S_EDIT1;
                end
                S_EDIT1: begin
                    r_state <= two_step ? S_EDIT2 : S_DONE;
                    if (!is_free && !r_found) begin
                        r_st <= ST_NOFIT;
                    end else if (need_new && ffull) begin
                        r_st <= ST_FULL;
                    end else if (!is_free) begin
                        r_ucnt <= r_ucnt + UC'(1);
                        r_ftot <= r_ftot - r_s[31:0];
                        r_st   <= ST_OK;
                        r_ra   <= r_a;
                        r_rs   <= r_s[31:0];
                        if (left && right) begin
                            r_fcnt <= r_fcnt + FC'(1);
                        end else if (!left && !right) begin
                            r_fcnt <= r_fcnt - FC'(1);
                        end
                    end else begin
                        r_ucnt <= r_ucnt - UC'(1);
                        r_ftot <= r_ftot + r_len;
                        r_st   <= ST_OK;
                        r_ra   <= r_a;
                        r_rs   <= r_len;
                        if (prev_t && next_t) begin
                            r_fcnt <= r_fcnt - FC'(1);
                        end else if (!prev_t && !next_t) begin
                            r_fcnt <= r_fcnt + FC'(1);
                        end
                    end
                end
                S_EDIT2: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_st;
                        r_o_addr    <= r_ra;
                        r_o_size    <= r_rs;
                        r_o_free    <= r_ftot;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_block_address = r_o_addr;
    assign o_block_size    = r_o_size;
    assign o_free_bytes    = r_o_free;

    `RAL_ASSERT(a_free_count_bound, r_fcnt <= FC'(FREE_RANGES))
    `RAL_ASSERT(a_used_count_bound, r_ucnt <= UC'(USED_BLOCKS))
    `RAL_ASSERT_MSG(a_busy_after_accept, (i_valid && !o_stall) |=> (r_state == S_CHECK),
        "accepted word did not start processing")
endmodule
`default_nettype wire
